[rtl/core/lcd4_pkg.sv]
// Shared types, codes and nibble tables for the 4-bit character LCD sequencer.
package lcd4_pkg;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_FLAG  = 3'd2,
        CMD_GOTO  = 3'd3,
        CMD_WRITE = 3'd4
    } t_cmd;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [1:0] FSEL_DISPLAY = 2'd0;
    localparam logic [1:0] FSEL_CURSOR  = 2'd1;
    localparam logic [1:0] FSEL_BLINK   = 2'd2;

    localparam logic [2:0] FLAG_DISPLAY_BIT = 3'h4;
    localparam logic [2:0] FLAG_CURSOR_BIT  = 3'h2;
    localparam logic [2:0] FLAG_BLINK_BIT   = 3'h1;

    localparam logic [7:0] INS_CLEAR     = 8'h01;
    localparam logic [7:0] INS_ENTRY     = 8'h04;
    localparam logic [7:0] ENTRY_INC     = 8'h02;
    localparam logic [7:0] INS_DISPCTL   = 8'h08;
    localparam logic [7:0] INS_FUNC      = 8'h20;
    localparam logic [7:0] FUNC_TWO_LINE = 8'h08;
    localparam logic [7:0] INS_DDRAM     = 8'h80;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;
    localparam logic [2:0] INIT_FLAGS    = 3'h4;

    localparam logic [12:0] WAIT_NONE  = 13'd0;
    localparam logic [12:0] WAIT_WAKE  = 13'd4500;
    localparam logic [12:0] WAIT_4BIT  = 13'd100;
    localparam logic [12:0] WAIT_CLEAR = 13'd4000;
    localparam logic [12:0] WAIT_ENTRY = 13'd4500;

    localparam logic [3:0] INIT_LAST = 4'd11;
    localparam logic [3:0] BYTE_LAST = 4'd1;

    // One queued request as the back end needs it
    typedef struct packed {
        logic        is_init;
        logic        rs;
        logic [7:0]  data;      // byte to send; function-set byte for init
        logic [12:0] low_wait;
        logic [5:0]  cur_x;
        logic [1:0]  cur_y;
    } t_entry;

    typedef struct packed {
        logic [3:0]  nibble;
        logic [12:0] wait_us;
    } t_nib;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        unique case (row)
            2'd0: b = 8'h00;
            2'd1: b = 8'h40;
            2'd2: b = 8'h14;
            2'd3: b = 8'h54;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic t_nib init_nibble(input logic [3:0] step, input logic [7:0] func);
        t_nib  n;
        logic [7:0] dctl;
        logic [7:0] entry;
        dctl  = INS_DISPCTL | {5'd0, INIT_FLAGS};
        entry = INS_ENTRY | ENTRY_INC;
        n.wait_us = WAIT_NONE;
        unique case (step)
            4'd0, 4'd1, 4'd2: begin
                n.nibble  = NIB_WAKE;
                n.wait_us = WAIT_WAKE;
            end
            4'd3: begin
                n.nibble  = NIB_FOUR_BIT;
                n.wait_us = WAIT_4BIT;
            end
            4'd4:  n.nibble = func[7:4];
            4'd5:  n.nibble = func[3:0];
            4'd6:  n.nibble = dctl[7:4];
            4'd7:  n.nibble = dctl[3:0];
            4'd8:  n.nibble = INS_CLEAR[7:4];
            4'd9: begin
                n.nibble  = INS_CLEAR[3:0];
                n.wait_us = WAIT_CLEAR;
            end
            4'd10: n.nibble = entry[7:4];
            4'd11: begin
                n.nibble  = entry[3:0];
                n.wait_us = WAIT_ENTRY;
            end
            default: n.nibble = 4'h0;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/char_lcd_4bit_command_sequencer.sv]
// Top level of the 4-bit character LCD request sequencer.
// Each accepted request word (init, clear, flag change, goto, write) is turned
// into LCD nibble transfers, high nibble first, one nibble word per cycle from
// the output register while the receiver does not stall. Clear, flag, goto and
// write give two nibble words each; init gives 12 words. The emitter, one nibble
// a cycle unless stalled, sets the rate; a queue of FIFO_DEPTH requests lets input
// be taken while it is busy. Unknown commands and flag selectors are taken and
// give no output. Write the configuration only while no request is in flight.
module char_lcd_4bit_command_sequencer #(
    parameter int MAX_ROWS   = 4,
    parameter int MAX_COLS   = 40,
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: index 0 rows_in_use, index 1 cols_in_use
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // command[2:0], col[8:3], row[11:9], flag_select[13:12], flag_value[14],
    // char_code[22:15], advance[23]
    input  logic [23:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // nibble[3:0], wait_us[16:4], cursor_x[22:17], cursor_y[24:23], zero[31:25]
    output logic [31:0] o_m_tdata,
    // reg_select[0]
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    lcd4_pkg::t_entry push_entry;
    lcd4_pkg::t_entry head;
    logic             push;
    logic             full;
    logic             pop;
    logic             nonempty;
    logic [3:0]       nibble;
    logic [12:0]      wait_us;
    logic [5:0]       cur_x;
    logic [1:0]       cur_y;

    lcd4_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_command     (i_s_tdata[2:0]),
        .i_col         (i_s_tdata[8:3]),
        .i_row         (i_s_tdata[11:9]),
        .i_flag_select (i_s_tdata[13:12]),
        .i_flag_value  (i_s_tdata[14]),
        .i_char_code   (i_s_tdata[22:15]),
        .i_advance     (i_s_tdata[23]),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    lcd4_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    lcd4_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_rs       (o_m_tuser),
        .o_nibble   (nibble),
        .o_wait_us  (wait_us),
        .o_cur_x    (cur_x),
        .o_cur_y    (cur_y),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, cur_y, cur_x, wait_us, nibble};

endmodule

[rtl/core/lcd4_front.sv]
// Front end: takes requests, keeps flags and cursor, queues the bytes to send.
module lcd4_front #(
    parameter int MAX_ROWS = 4,
    parameter int MAX_COLS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_command,
    input  logic [5:0]        i_col,
    input  logic [2:0]        i_row,
    input  logic [1:0]        i_flag_select,
    input  logic              i_flag_value,
    input  logic [7:0]        i_char_code,
    input  logic              i_advance,
    input  logic              i_full,
    output logic              o_push,
    output lcd4_pkg::t_entry  o_entry
);

    logic [2:0] r_rows, n_rows;
    logic [5:0] r_cols, n_cols;
    logic [2:0] r_flags, n_flags;
    logic [5:0] r_cx, n_cx;
    logic [1:0] r_cy, n_cy;

    logic [2:0] eff_rows;
    logic [5:0] eff_cols;
    logic       accept;
    logic       emit;
    logic [2:0] flag_bit;
    logic       flag_ok;
    logic [2:0] goto_row;
    logic [5:0] goto_col;
    logic [6:0] x_inc;
    logic [2:0] y_inc;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        eff_rows = r_rows;
        if (r_rows == 3'd0) eff_rows = 3'd1;
        else if (r_rows > 3'(MAX_ROWS)) eff_rows = 3'(MAX_ROWS);
        eff_cols = r_cols;
        if (r_cols == 6'd0) eff_cols = 6'd1;
        else if (r_cols > 6'(MAX_COLS)) eff_cols = 6'(MAX_COLS);
    end

    always_comb begin
        flag_ok = 1'b1;
        unique case (i_flag_select)
            lcd4_pkg::FSEL_DISPLAY: flag_bit = lcd4_pkg::FLAG_DISPLAY_BIT;
            lcd4_pkg::FSEL_CURSOR:  flag_bit = lcd4_pkg::FLAG_CURSOR_BIT;
            lcd4_pkg::FSEL_BLINK:   flag_bit = lcd4_pkg::FLAG_BLINK_BIT;
            default: begin
                flag_bit = 3'd0;
                flag_ok  = 1'b0;
            end
        endcase
        goto_row = (i_row < eff_rows) ? i_row : 3'd0;
        goto_col = (i_col < 6'(MAX_COLS)) ? i_col : 6'd0;
        x_inc    = {1'b0, r_cx} + 7'd1;
        y_inc    = {1'b0, r_cy} + 3'd1;
    end

    always_comb begin
        n_rows  = r_rows;
        n_cols  = r_cols;
        if (i_cfg_we) begin
            if (i_cfg_index == lcd4_pkg::CFG_ROWS) n_rows = i_cfg_data[2:0];
            else n_cols = i_cfg_data;
        end
        n_flags = r_flags;
        n_cx    = r_cx;
        n_cy    = r_cy;
        emit    = 1'b0;
        o_entry = '0;
        unique case (lcd4_pkg::t_cmd'(i_command))
            lcd4_pkg::CMD_INIT: begin
                emit            = 1'b1;
                n_flags         = lcd4_pkg::INIT_FLAGS;
                n_cx            = 6'd0;
                n_cy            = 2'd0;
                o_entry.is_init = 1'b1;
                o_entry.data    = lcd4_pkg::INS_FUNC |
                                  ((eff_rows > 3'd1) ? lcd4_pkg::FUNC_TWO_LINE : 8'h00);
            end
            lcd4_pkg::CMD_CLEAR: begin
                emit             = 1'b1;
                n_cx             = 6'd0;
                n_cy             = 2'd0;
                o_entry.data     = lcd4_pkg::INS_CLEAR;
                o_entry.low_wait = lcd4_pkg::WAIT_CLEAR;
            end
            lcd4_pkg::CMD_FLAG: begin
                emit         = flag_ok;
                n_flags      = i_flag_value ? (r_flags | flag_bit) : (r_flags & ~flag_bit);
                o_entry.data = lcd4_pkg::INS_DISPCTL | {5'd0, n_flags};
            end
            lcd4_pkg::CMD_GOTO: begin
                emit         = 1'b1;
                n_cx         = goto_col;
                n_cy         = goto_row[1:0];
                o_entry.data = lcd4_pkg::INS_DDRAM |
                               ({2'd0, goto_col} + lcd4_pkg::row_base(goto_row[1:0]));
            end
            lcd4_pkg::CMD_WRITE: begin
                emit         = 1'b1;
                o_entry.rs   = 1'b1;
                o_entry.data = i_char_code;
                if (i_advance) begin
                    // wrap to the next row, and back to the top after the last one
                    if (x_inc >= {1'b0, eff_cols}) begin
                        n_cx = 6'd0;
                        n_cy = (y_inc >= eff_rows) ? 2'd0 : y_inc[1:0];
                    end else begin
                        n_cx = x_inc[5:0];
                    end
                end
            end
            default: emit = 1'b0;
        endcase
        o_entry.cur_x = n_cx;
        o_entry.cur_y = n_cy;
        o_push = accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= 3'd2;
            r_cols  <= 6'd16;
            r_flags <= 3'd0;
            r_cx    <= 6'd0;
            r_cy    <= 2'd0;
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
            if (accept) begin
                r_flags <= n_flags;
                r_cx    <= n_cx;
                r_cy    <= n_cy;
            end
        end
    end

endmodule

[rtl/core/lcd4_fifo.sv]
// Short request queue between the front and back ends.
module lcd4_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcd4_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_nonempty,
    output lcd4_pkg::t_entry  o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lcd4_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        if (i_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        if (i_push && !i_pop) n_count = r_count + CW'(1);
        else if (!i_push && i_pop) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/core/lcd4_back.sv]
// Back end: splits queued bytes into nibbles and drives the output register.
module lcd4_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  lcd4_pkg::t_entry  i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_rs,
    output logic [3:0]        o_nibble,
    output logic [12:0]       o_wait_us,
    output logic [5:0]        o_cur_x,
    output logic [1:0]        o_cur_y,
    output logic              o_last
);

    logic [3:0]       r_step, n_step;
    logic             r_valid, n_valid;
    logic             r_rs;
    logic [3:0]       r_nibble;
    logic [12:0]      r_wait;
    logic [5:0]       r_cx;
    logic [1:0]       r_cy;
    logic             r_last;
    logic             load;
    logic             is_last;
    lcd4_pkg::t_nib   nib;
    lcd4_pkg::t_nib   init_nib;

    assign init_nib = lcd4_pkg::init_nibble(r_step, i_head.data);

    always_comb begin
        if (i_head.is_init) begin
            nib     = init_nib;
            is_last = (r_step == lcd4_pkg::INIT_LAST);
        end else begin
            nib.nibble  = (r_step == 4'd0) ? i_head.data[7:4] : i_head.data[3:0];
            nib.wait_us = (r_step == 4'd0) ? lcd4_pkg::WAIT_NONE : i_head.low_wait;
            is_last     = (r_step == lcd4_pkg::BYTE_LAST);
        end
    end

    // load the next nibble whenever the output slot is free or being taken
    assign load  = i_nonempty && (!r_valid || i_ready);
    assign o_pop = load && is_last;

    always_comb begin
        n_valid = r_valid;
        if (load) n_valid = 1'b1;
        else if (i_ready) n_valid = 1'b0;
        n_step = r_step;
        if (load) n_step = is_last ? 4'd0 : r_step + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs     <= i_head.rs;
            r_nibble <= nib.nibble;
            r_wait   <= nib.wait_us;
            r_cx     <= i_head.cur_x;
            r_cy     <= i_head.cur_y;
            r_last   <= is_last;
        end
    end

    assign o_valid   = r_valid;
    assign o_rs      = r_rs;
    assign o_nibble  = r_nibble;
    assign o_wait_us = r_wait;
    assign o_cur_x   = r_cx;
    assign o_cur_y   = r_cy;
    assign o_last    = r_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= lcd4_pkg::INIT_LAST)
        else $error("nibble step out of range");

    a_step_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_nonempty && !i_head.is_init) |-> (r_step <= lcd4_pkg::BYTE_LAST))
        else $error("byte request past its second nibble");

    a_step_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 4'd0) |-> i_nonempty)
        else $error("request left the queue mid-sequence");

endmodule

[tb/char_lcd_4bit_command_sequencer_tb.sv]
// Self-checking testbench for the 4-bit character LCD request sequencer.
`timescale 1ns / 1ps

typedef struct {
    bit        rs;
    bit [3:0]  nibble;
    bit [12:0] wait_us;
    bit [5:0]  cursor_x;
    bit [1:0]  cursor_y;
    bit        last;
} t_nibble_word;

class lcd_nibble_scoreboard;
    localparam int LCD_ROWS = 4;
    localparam int LCD_COLS = 40;

    bit [2:0]  rows_reg = 3'd2;
    bit [5:0]  cols_reg = 6'd16;
    bit [2:0]  flags    = 3'd0;
    bit [5:0]  cur_col  = 6'd0;
    bit [1:0]  cur_row  = 2'd0;
    bit [7:0]  row_offset [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    int        errors   = 0;

    t_nibble_word due_words[$];
    t_nibble_word staged[$];

    function int rows_eff();
        if (rows_reg == 0) return 1;
        if (rows_reg > LCD_ROWS) return LCD_ROWS;
        return rows_reg;
    endfunction

    function int cols_eff();
        if (cols_reg == 0) return 1;
        if (cols_reg > LCD_COLS) return LCD_COLS;
        return cols_reg;
    endfunction

    function void set_reg(bit idx, bit [5:0] value);
        if (idx == lcd4_pkg::CFG_ROWS) rows_reg = value[2:0];
        else cols_reg = value;
    endfunction

    function int pending();
        return due_words.size();
    endfunction

    function void stage(bit rs, bit [3:0] nib, bit [12:0] wt);
        t_nibble_word e;
        e.rs       = rs;
        e.nibble   = nib;
        e.wait_us  = wt;
        e.cursor_x = 6'd0;
        e.cursor_y = 2'd0;
        e.last     = 1'b0;
        staged.push_back(e);
    endfunction

    // high nibble carries no wait; the wait follows the low nibble
    function void stage_byte(bit rs, bit [7:0] b, bit [12:0] wt);
        stage(rs, b[7:4], lcd4_pkg::WAIT_NONE);
        stage(rs, b[3:0], wt);
    endfunction

    function void note_request(logic [23:0] w);
        bit [5:0] col;
        bit [2:0] row;
        bit [1:0] fsel;
        bit       fval;
        bit [7:0] ch;
        bit       adv;
        bit [7:0] func;
        bit [2:0] flag_mask;
        int       x;
        int       y;
        col  = w[8:3];
        row  = w[11:9];
        fsel = w[13:12];
        fval = w[14];
        ch   = w[22:15];
        adv  = w[23];
        staged.delete();
        case (w[2:0])
            lcd4_pkg::CMD_INIT: begin
                func = lcd4_pkg::INS_FUNC;
                if (rows_eff() > 1) func = func | lcd4_pkg::FUNC_TWO_LINE;
                cur_col = 6'd0;
                cur_row = 2'd0;
                flags   = lcd4_pkg::INIT_FLAGS;
                stage(1'b0, lcd4_pkg::NIB_WAKE, lcd4_pkg::WAIT_WAKE);
                stage(1'b0, lcd4_pkg::NIB_WAKE, lcd4_pkg::WAIT_WAKE);
                stage(1'b0, lcd4_pkg::NIB_WAKE, lcd4_pkg::WAIT_WAKE);
                stage(1'b0, lcd4_pkg::NIB_FOUR_BIT, lcd4_pkg::WAIT_4BIT);
                stage_byte(1'b0, func, lcd4_pkg::WAIT_NONE);
                stage_byte(1'b0, lcd4_pkg::INS_DISPCTL | {5'd0, flags}, lcd4_pkg::WAIT_NONE);
                stage_byte(1'b0, lcd4_pkg::INS_CLEAR, lcd4_pkg::WAIT_CLEAR);
                stage_byte(1'b0, lcd4_pkg::INS_ENTRY | lcd4_pkg::ENTRY_INC,
                           lcd4_pkg::WAIT_ENTRY);
            end
            lcd4_pkg::CMD_CLEAR: begin
                cur_col = 6'd0;
                cur_row = 2'd0;
                stage_byte(1'b0, lcd4_pkg::INS_CLEAR, lcd4_pkg::WAIT_CLEAR);
            end
            lcd4_pkg::CMD_FLAG: begin
                case (fsel)
                    lcd4_pkg::FSEL_DISPLAY: flag_mask = lcd4_pkg::FLAG_DISPLAY_BIT;
                    lcd4_pkg::FSEL_CURSOR:  flag_mask = lcd4_pkg::FLAG_CURSOR_BIT;
                    lcd4_pkg::FSEL_BLINK:   flag_mask = lcd4_pkg::FLAG_BLINK_BIT;
                    default:                return;   // drop unknown selector
                endcase
                flags = fval ? (flags | flag_mask) : (flags & ~flag_mask);
                stage_byte(1'b0, lcd4_pkg::INS_DISPCTL | {5'd0, flags}, lcd4_pkg::WAIT_NONE);
            end
            lcd4_pkg::CMD_GOTO: begin
                if (row >= rows_eff()) row = 3'd0;
                if (col >= LCD_COLS) col = 6'd0;
                cur_col = col;
                cur_row = row[1:0];
                stage_byte(1'b0,
                           lcd4_pkg::INS_DDRAM | ({2'd0, col} + row_offset[row[1:0]]),
                           lcd4_pkg::WAIT_NONE);
            end
            lcd4_pkg::CMD_WRITE: begin
                stage_byte(1'b1, ch, lcd4_pkg::WAIT_NONE);
                if (adv) begin
                    x = cur_col + 1;
                    if (x >= cols_eff()) begin
                        x = 0;
                        y = cur_row + 1;
                        if (y >= rows_eff()) y = 0;
                        cur_row = y[1:0];
                    end
                    cur_col = x[5:0];
                end
            end
            default: return;
        endcase
        foreach (staged[i]) begin
            staged[i].cursor_x = cur_col;
            staged[i].cursor_y = cur_row;
            staged[i].last     = (i == staged.size() - 1);
            due_words.push_back(staged[i]);
        end
    endfunction

    function void compare_field(string name, int unsigned want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_word(logic [31:0] d, logic rs, logic lst);
        t_nibble_word e;
        if (due_words.size() == 0) begin
            $error("nibble word %h with nothing expected", d);
            errors++;
            return;
        end
        e = due_words.pop_front();
        compare_field("reg_select", e.rs, {31'd0, rs});
        compare_field("nibble", e.nibble, {28'd0, d[3:0]});
        compare_field("wait_us", e.wait_us, {19'd0, d[16:4]});
        compare_field("cursor_x", e.cursor_x, {26'd0, d[22:17]});
        compare_field("cursor_y", e.cursor_y, {30'd0, d[24:23]});
        compare_field("last", e.last, {31'd0, lst});
        compare_field("pad", 0, {25'd0, d[31:25]});
    endfunction
endclass

module char_lcd_4bit_command_sequencer_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 16;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [5:0]  i_cfg_data = 6'd0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = 24'd0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    int send_idle  = 0;
    int recv_stall = 0;
    int cycle_count = 0;

    lcd_nibble_scoreboard board = new();

    char_lcd_4bit_command_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // nibble word sink: check on handshake, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_word(o_m_tdata, o_m_tuser, o_m_tlast);
        i_m_tready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [23:0] pack_request(bit [2:0] cmd, bit [5:0] col, bit [2:0] row,
                                                 bit [1:0] fsel, bit fval, bit [7:0] ch,
                                                 bit adv);
        return {adv, ch, fval, fsel, row, col, cmd};
    endfunction

    function automatic logic [23:0] make_request();
        int       pick;
        bit [2:0] cmd;
        bit [5:0] col;
        pick = $urandom_range(99);
        if (pick < 4) cmd = lcd4_pkg::CMD_INIT;
        else if (pick < 10) cmd = lcd4_pkg::CMD_CLEAR;
        else if (pick < 24) cmd = lcd4_pkg::CMD_FLAG;
        else if (pick < 44) cmd = lcd4_pkg::CMD_GOTO;
        else if (pick < 94) cmd = lcd4_pkg::CMD_WRITE;
        else cmd = 3'($urandom_range(7, 5));
        // mostly legal columns, now and then one past the display
        col = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(39));
        return pack_request(cmd, col, 3'($urandom_range(7)), 2'($urandom_range(3)),
                            1'($urandom_range(1)), 8'($urandom_range(255)),
                            ($urandom_range(3) != 0));
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 54; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 54; end
            default: begin send_idle = 38; recv_stall = 38; end
        endcase
    endtask

    task automatic send_request(input logic [23:0] w);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_request(w);
    endtask

    // hold the sender until every nibble word is out, then let ignored words clear
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(input bit [5:0] rows_word, input bit [5:0] cols_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lcd4_pkg::CFG_ROWS;
        i_cfg_data  <= rows_word;
        @(posedge i_clk);
        board.set_reg(lcd4_pkg::CFG_ROWS, rows_word);
        i_cfg_index <= lcd4_pkg::CFG_COLS;
        i_cfg_data  <= cols_word;
        @(posedge i_clk);
        board.set_reg(lcd4_pkg::CFG_COLS, cols_word);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input bit [2:0] rows, input bit [5:0] cols, input int mode,
                             input int count, input int pause_at);
        drain();
        // upper data bits are don't-care for the row count
        write_regs({3'($urandom_range(7)), rows}, cols);
        set_idling(mode);
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) drain();
            send_request(make_request());
        end
    endtask

    initial begin
        logic [23:0] opening[$];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small display so advancing writes wrap column and row quickly
        write_regs(6'd4, 6'd3);
        set_idling(0);
        opening.push_back(pack_request(lcd4_pkg::CMD_INIT, 0, 0, 0, 0, 8'h00, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_FLAG, 0, 0,
                                       lcd4_pkg::FSEL_DISPLAY, 0, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_FLAG, 0, 0,
                                       lcd4_pkg::FSEL_CURSOR, 1, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_FLAG, 0, 0,
                                       lcd4_pkg::FSEL_BLINK, 1, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_FLAG, 0, 0, 2'd3, 1, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_FLAG, 0, 0,
                                       lcd4_pkg::FSEL_DISPLAY, 1, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_FLAG, 0, 0,
                                       lcd4_pkg::FSEL_BLINK, 0, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_GOTO, 6'd39, 3'd3, 0, 0, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_GOTO, 6'd63, 3'd7, 0, 0, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_GOTO, 6'd40, 3'd2, 0, 0, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_GOTO, 6'd2, 3'd3, 0, 0, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_WRITE, 0, 0, 0, 0, 8'hFF, 1));
        opening.push_back(pack_request(lcd4_pkg::CMD_WRITE, 0, 0, 0, 0, 8'h00, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_WRITE, 0, 0, 0, 0, 8'hA5, 1));
        opening.push_back(pack_request(lcd4_pkg::CMD_WRITE, 0, 0, 0, 0, 8'h5A, 1));
        opening.push_back(pack_request(lcd4_pkg::CMD_WRITE, 0, 0, 0, 0, 8'h7E, 1));
        opening.push_back(pack_request(lcd4_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        opening.push_back(pack_request(3'd5, 6'd21, 3'd5, 2'd2, 1, 8'h3C, 1));
        opening.push_back(pack_request(3'd6, 0, 0, 0, 0, 0, 0));
        opening.push_back(24'hFFFFFF);
        opening.push_back(pack_request(lcd4_pkg::CMD_GOTO, 6'd0, 3'd1, 0, 0, 0, 0));
        opening.push_back(pack_request(lcd4_pkg::CMD_WRITE, 0, 0, 0, 0, 8'h80, 1));
        opening.push_back(pack_request(lcd4_pkg::CMD_INIT, 6'd63, 3'd7, 2'd3, 1, 8'hFF, 1));
        foreach (opening[i]) send_request(opening[i]);

        run_phase(3'd2, 6'd16, 0, 31, -1);
        run_phase(3'd0, 6'd0,  1, 31, -1);
        run_phase(3'd7, 6'd63, 2, 31, -1);
        run_phase(3'd1, 6'd40, 3, 31, -1);
        run_phase(3'd4, 6'd1,  0, 31, -1);
        run_phase(3'd3, 6'd5,  1, 31, 17);
        run_phase(3'($urandom_range(7)), 6'($urandom_range(63)), 2, 31, -1);
        run_phase(3'($urandom_range(7)), 6'($urandom_range(63)), 3, 31, -1);

        drain();
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
